[hw/rtl/flow_packet_byte_counter_macros.svh]
// ---------------------------------------------------------------------------
// Flow packet byte counter assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef FLOW_PACKET_BYTE_COUNTER_MACROS_SVH
`define FLOW_PACKET_BYTE_COUNTER_MACROS_SVH

// Implication checked at every edge outside reset.
`define FPBC_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fpbc assertion failed");

// Plain invariant checked at every edge outside reset.
`define FPBC_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("fpbc invariant failed");

`endif

[hw/rtl/fpbc_pkg.sv]
// ---------------------------------------------------------------------------
// Flow packet byte counter package
// Table size, codes and the request record that walks the cell chain.
// ---------------------------------------------------------------------------
package fpbc_pkg;

   localparam int FLOW_ENTRIES = 64;
   localparam int POS_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CMP_W = (POS_W > 6) ? POS_W : 6;

   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_COUNTED = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic       ACT_BYTE = 1'b0;
   localparam logic       ACT_READ = 1'b1;
   localparam logic       KIND_PACKET = 1'b0;
   localparam logic       KIND_READ   = 1'b1;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [3:0]  IP_VER4    = 4'd4;

   typedef struct packed {
      logic [1:0]       op;
      logic             done;
      logic             kind;
      logic [1:0]       status;
      logic [5:0]       entry_index;
      logic [5:0]       read_index;
      logic [POS_W-1:0] pos;
      logic             entry_valid;
      logic [31:0]      saddr;
      logic [31:0]      daddr;
      logic [15:0]      sport;
      logic [15:0]      dport;
      logic [15:0]      payload;
      logic [31:0]      pkts;
      logic [47:0]      bytes;
   } probe_type;

endpackage

[hw/rtl/flow_packet_byte_counter.sv]
// ---------------------------------------------------------------------------
// Flow packet byte counter
// Per-flow packet and payload byte statistics for IPv4 TCP/UDP frames.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one request per cycle while req_tready is high. tuser =
//   action (0 frame byte, 1 read entry), tlast marks the last captured byte
//   of a frame, tdata holds the byte and the read index. Frame bytes without
//   tlast are taken every cycle while no lookup is pending; they give no response.
//   A frame end or a read launches a lookup that walks the chain of
//   FLOW_ENTRIES table cells, one cell per cycle. One parser register, one
//   register per cell and the response register lie between the accepting
//   edge and rsp; the response can be taken at the next edge at the earliest.
//   While a lookup is in flight or its response waits, req_tready is low and
//   rises the cycle after the response is taken, so a new frame end or read
//   is only accepted once the previous response is taken, and any rsp stall
//   delays it further.
//   rsp channel: tuser = kind (0 packet report, 1 entry readout); tdata holds
//   status, entry fields and totals. A stalled response holds unchanged.
//   Reset empties the table at once (one used bit per cell) and clears the
//   frame parser; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "flow_packet_byte_counter_macros.svh"

module flow_packet_byte_counter import fpbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // [7:0] data_byte, [13:8] read_index, rest zero
   input  logic         req_tlast,  // last_byte
   input  logic         req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [7:2] entry_index, [8] entry_valid, [40:9] source_address,
   // [72:41] destination_address, [88:73] src_port, [104:89] destination_port,
   // [120:105] payload_bytes, [152:121] packet_total, [200:153] byte_total
   output logic [207:0] rsp_tdata,
   output logic         rsp_tuser   // kind
);

   logic      accept, rsp_take;
   logic      launch_valid;
   probe_type launch_probe;
   logic      busy_ff, busy_in;
   logic      rv_ff, rv_in;
   probe_type rp_ff, rp_in;
   logic      [FLOW_ENTRIES:0] chain_valid;
   probe_type chain_probe [FLOW_ENTRIES+1];

   assign accept = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign req_tready = !busy_ff;

   fpbc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_tuser),
      .data_byte    (req_tdata[7:0]),
      .last_byte    (req_tlast),
      .read_index   (req_tdata[13:8]),
      .launch_valid (launch_valid),
      .launch_probe (launch_probe)
   );

   // request enters the chain at cell 0 with position 0
   always_comb begin
      chain_valid[0] = launch_valid;
      chain_probe[0] = launch_probe;
      chain_probe[0].pos = '0;
   end

   for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
      fpbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_probe  (chain_probe[g]),
         .out_valid (chain_valid[g+1]),
         .out_probe (chain_probe[g+1])
      );
   end

   // finish the request at the chain tail: an update no cell took means a full table
   always_comb begin
      busy_in = busy_ff;
      if (accept && (req_tuser == ACT_READ || req_tlast)) busy_in = 1'b1;
      if (rsp_take) busy_in = 1'b0;
      rv_in = rv_ff;
      rp_in = rp_ff;
      if (rsp_take) rv_in = 1'b0;
      if (chain_valid[FLOW_ENTRIES]) begin
         rv_in = 1'b1;
         rp_in = chain_probe[FLOW_ENTRIES];
         if (rp_in.op == OP_UPDATE && !rp_in.done) begin
            rp_in.status = ST_FULL;
            rp_in.entry_index = '0;
            rp_in.entry_valid = 1'b0;
            rp_in.pkts = '0;
            rp_in.bytes = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rv_ff <= rv_in;
      end
      rp_ff <= rp_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser = rp_ff.kind;
   assign rsp_tdata = {7'd0, rp_ff.bytes, rp_ff.pkts, rp_ff.payload, rp_ff.dport,
                       rp_ff.sport, rp_ff.daddr, rp_ff.saddr, rp_ff.entry_valid,
                       rp_ff.entry_index, rp_ff.status};

   `FPBC_ASSERT_IMPLY(a_rsp_while_busy, rv_ff, busy_ff)
   `FPBC_ASSERT_ALWAYS(a_one_in_flight, $onehot0(chain_valid))
   `FPBC_ASSERT_IMPLY(a_tail_no_pending, chain_valid[FLOW_ENTRIES], !rv_ff)
   `FPBC_ASSERT_IMPLY(a_full_not_valid, rv_ff && rp_ff.status == ST_FULL, !rp_ff.entry_valid)

endmodule

[hw/rtl/fpbc_parser.sv]
// ---------------------------------------------------------------------------
// Flow packet byte counter frame parser
// Collect header fields byte by byte and launch one request per frame end or read.
// ---------------------------------------------------------------------------
module fpbc_parser import fpbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        action,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   input  logic [5:0]  read_index,
   output logic        launch_valid,
   output probe_type   launch_probe
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  ivl_ff, ivl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] sa_ff, sa_in;
   logic [31:0] da_ff, da_in;
   logic [15:0] sp_ff, sp_in;
   logic [15:0] dp_ff, dp_in;
   logic [3:0]  off_ff, off_in;
   logic        lv_ff, lv_in;
   probe_type   lp_ff, lp_in;

   logic [15:0] t_cur, t_new, need, len, sub, pay;
   logic        is_tcp, ok;

   always_comb begin
      t_cur = 16'd14 + {10'd0, ivl_ff[3:0], 2'b00};
      etype_in = etype_ff;
      ivl_in = ivl_ff;
      proto_in = proto_ff;
      sa_in = sa_ff;
      da_in = da_ff;
      sp_in = sp_ff;
      dp_in = dp_ff;
      off_in = off_ff;
      pos_in = pos_ff;
      lv_in = 1'b0;
      lp_in = '0;
      if (pos_ff == 16'd12) etype_in = {data_byte, etype_ff[7:0]};
      else if (pos_ff == 16'd13) etype_in = {etype_ff[15:8], data_byte};
      else if (pos_ff == 16'd14) ivl_in = data_byte;
      else if (pos_ff == 16'd23) proto_in = data_byte;
      else if (pos_ff >= 16'd26 && pos_ff <= 16'd29) sa_in = {sa_ff[23:0], data_byte};
      else if (pos_ff >= 16'd30 && pos_ff <= 16'd33) da_in = {da_ff[23:0], data_byte};
      if (pos_ff == t_cur) sp_in = {data_byte, sp_ff[7:0]};
      else if (pos_ff == t_cur + 16'd1) sp_in = {sp_ff[15:8], data_byte};
      else if (pos_ff == t_cur + 16'd2) dp_in = {data_byte, dp_ff[7:0]};
      else if (pos_ff == t_cur + 16'd3) dp_in = {dp_ff[15:8], data_byte};
      else if (pos_ff == t_cur + 16'd12) off_in = data_byte[7:4];
      len = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : 16'hFFFF;
      // checks use the values just captured
      t_new = 16'd14 + {10'd0, ivl_in[3:0], 2'b00};
      is_tcp = (proto_in == PROTO_TCP);
      need = is_tcp ? t_new + 16'd13 : t_new + 16'd4;
      ok = (len >= 16'd24) && (etype_in == ETYPE_IPV4) && (ivl_in[7:4] == IP_VER4) &&
           (ivl_in[3:0] >= 4'd5) && (is_tcp || proto_in == PROTO_UDP) && (len >= need);
      sub = t_new + (is_tcp ? {10'd0, off_in, 2'b00} : 16'd8);
      pay = (len > sub) ? len - sub : 16'd0;
      if (accept) begin
         if (action == ACT_READ) begin
            lv_in = 1'b1;
            lp_in.op = OP_READ;
            lp_in.kind = KIND_READ;
            lp_in.status = ST_COUNTED;
            lp_in.entry_index = read_index;
            lp_in.read_index = read_index;
            // drop the frame byte on a read step
            etype_in = etype_ff;
            ivl_in = ivl_ff;
            proto_in = proto_ff;
            sa_in = sa_ff;
            da_in = da_ff;
            sp_in = sp_ff;
            dp_in = dp_ff;
            off_in = off_ff;
         end else if (last_byte) begin
            pos_in = 16'd0;
            lv_in = 1'b1;
            lp_in.kind = KIND_PACKET;
            if (ok) begin
               lp_in.op = OP_UPDATE;
               lp_in.status = ST_COUNTED;
               lp_in.saddr = sa_in;
               lp_in.daddr = da_in;
               lp_in.sport = sp_in;
               lp_in.dport = dp_in;
               lp_in.payload = pay;
            end else begin
               lp_in.op = OP_NONE;
               lp_in.status = ST_IGNORED;
            end
         end else begin
            pos_in = len;
         end
      end else begin
         etype_in = etype_ff;
         ivl_in = ivl_ff;
         proto_in = proto_ff;
         sa_in = sa_ff;
         da_in = da_ff;
         sp_in = sp_ff;
         dp_in = dp_ff;
         off_in = off_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         etype_ff <= '0;
         ivl_ff <= '0;
         proto_ff <= '0;
         sa_ff <= '0;
         da_ff <= '0;
         sp_ff <= '0;
         dp_ff <= '0;
         off_ff <= '0;
         lv_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         etype_ff <= etype_in;
         ivl_ff <= ivl_in;
         proto_ff <= proto_in;
         sa_ff <= sa_in;
         da_ff <= da_in;
         sp_ff <= sp_in;
         dp_ff <= dp_in;
         off_ff <= off_in;
         lv_ff <= lv_in;
      end
      lp_ff <= lp_in;
   end

   assign launch_valid = lv_ff;
   assign launch_probe = lp_ff;

endmodule

[hw/rtl/fpbc_cell.sv]
// ---------------------------------------------------------------------------
// Flow packet byte counter table cell
// Hold one flow entry; match, allocate or read it as a request passes by.
// ---------------------------------------------------------------------------
module fpbc_cell import fpbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  probe_type in_probe,
   output logic      out_valid,
   output probe_type out_probe
);

   logic        used_ff, used_in;
   logic [31:0] sa_ff, da_ff, sa_in, da_in;
   logic [15:0] sp_ff, dp_ff, sp_in, dp_in;
   logic [31:0] pk_ff, pk_in;
   logic [47:0] by_ff, by_in;
   logic        ov_ff, ov_in;
   probe_type   op_ff, op_in;

   logic        live, key_hit, hit, alloc, rd;
   logic [31:0] pk_inc;
   logic [48:0] bsum;

   always_comb begin
      live = in_valid && in_probe.op == OP_UPDATE && !in_probe.done;
      key_hit = sa_ff == in_probe.saddr && da_ff == in_probe.daddr &&
                sp_ff == in_probe.sport && dp_ff == in_probe.dport;
      hit = live && used_ff && key_hit;
      alloc = live && !used_ff;
      rd = in_valid && in_probe.op == OP_READ && used_ff &&
           CMP_W'(in_probe.pos) == CMP_W'(in_probe.read_index);
      pk_inc = (pk_ff == '1) ? pk_ff : pk_ff + 32'd1;
      bsum = {1'b0, by_ff} + {33'd0, in_probe.payload};
      used_in = used_ff | alloc;
      sa_in = alloc ? in_probe.saddr : sa_ff;
      da_in = alloc ? in_probe.daddr : da_ff;
      sp_in = alloc ? in_probe.sport : sp_ff;
      dp_in = alloc ? in_probe.dport : dp_ff;
      pk_in = alloc ? 32'd1 : (hit ? pk_inc : pk_ff);
      by_in = alloc ? {32'd0, in_probe.payload} :
              (hit ? (bsum[48] ? '1 : bsum[47:0]) : by_ff);
      ov_in = in_valid;
      op_in = in_probe;
      op_in.pos = in_probe.pos + POS_W'(1);
      if (hit || alloc) begin
         op_in.done = 1'b1;
         op_in.status = ST_COUNTED;
         op_in.entry_index = 6'(in_probe.pos);
         op_in.entry_valid = 1'b1;
         op_in.pkts = pk_in;
         op_in.bytes = by_in;
      end else if (rd) begin
         op_in.entry_valid = 1'b1;
         op_in.saddr = sa_ff;
         op_in.daddr = da_ff;
         op_in.sport = sp_ff;
         op_in.dport = dp_ff;
         op_in.pkts = pk_ff;
         op_in.bytes = by_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         ov_ff <= ov_in;
      end
      sa_ff <= sa_in;
      da_ff <= da_in;
      sp_ff <= sp_in;
      dp_ff <= dp_in;
      pk_ff <= pk_in;
      by_ff <= by_in;
      op_ff <= op_in;
   end

   assign out_valid = ov_ff;
   assign out_probe = op_ff;

endmodule

[dv/flow_packet_byte_counter_tb.sv]
// ---------------------------------------------------------------------------
// Flow packet byte counter testbench
// Streams crafted IPv4 TCP/UDP frames, junk frames and entry reads into the
// counter, predicts each report from its own copy of the flow table and
// compares the responses field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module flow_packet_byte_counter_tb;
   import fpbc_pkg::*;

   typedef struct packed {
      logic       act;
      logic [7:0] data;
      logic       last;
      logic [5:0] index;
   } request_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [5:0]  entry_index;
      logic        entry_valid;
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] payload;
      logic [31:0] pkts;
      logic [47:0] bytes;
   } report_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;
   logic         rsp_tuser;

   flow_packet_byte_counter DUT (.*);

   always #5 clock = ~clock;

   request_type pending_requests[$];
   report_type  expected_reports[$];
   int          failures = 0;
   int          send_idle_pct = 29;
   int          recv_idle_pct = 71;
   int          hold_off_cycles = 0;
   logic        testing_done = 1'b0;

   // Predictor state: frame parser and flow table.
   logic [15:0] frame_pos;
   logic [15:0] ether_kind;
   logic [7:0]  ver_ihl;
   logic [7:0]  proto;
   logic [31:0] hdr_saddr, hdr_daddr;
   logic [15:0] hdr_sport, hdr_dport;
   logic [3:0]  tcp_words;
   logic [95:0] table_keys[FLOW_ENTRIES];
   logic [31:0] table_pkts[FLOW_ENTRIES];
   logic [47:0] table_bytes[FLOW_ENTRIES];
   logic        table_used[FLOW_ENTRIES];
   int          flows_used;

   function automatic report_type entry_report(int i);
      report_type r;
      r = '0;
      r.entry_index = i[5:0];
      r.entry_valid = 1'b1;
      {r.saddr, r.daddr, r.sport, r.dport} = table_keys[i];
      r.pkts = table_pkts[i];
      r.bytes = table_bytes[i];
      return r;
   endfunction

   function automatic report_type close_frame(int len);
      report_type r;
      int ihl, hdr_end, need, l4, pay, slot;
      logic is_tcp;
      logic [95:0] key;
      r = '0;
      r.kind = KIND_PACKET;
      ihl = ver_ihl[3:0];
      hdr_end = 14 + ihl * 4;
      if (len < 24 || ether_kind != ETYPE_IPV4 || ver_ihl[7:4] != IP_VER4 || ihl < 5 ||
          (proto != PROTO_TCP && proto != PROTO_UDP)) begin
         r.status = ST_IGNORED;
         return r;
      end
      is_tcp = (proto == PROTO_TCP);
      need = is_tcp ? hdr_end + 13 : hdr_end + 4;
      if (len < need) begin
         r.status = ST_IGNORED;
         return r;
      end
      l4 = is_tcp ? tcp_words * 4 : 8;
      pay = len - hdr_end - l4;
      if (pay < 0) pay = 0;
      key = {hdr_saddr, hdr_daddr, hdr_sport, hdr_dport};
      slot = -1;
      for (int i = 0; i < FLOW_ENTRIES; i++)
         if (slot < 0 && table_used[i] && table_keys[i] == key) slot = i;
      if (slot < 0) begin
         if (flows_used >= FLOW_ENTRIES) begin
            r.status = ST_FULL;
            {r.saddr, r.daddr, r.sport, r.dport} = key;
            r.payload = pay[15:0];
            return r;
         end
         slot = flows_used++;
         table_used[slot] = 1'b1;
         table_keys[slot] = key;
         table_pkts[slot] = '0;
         table_bytes[slot] = '0;
      end
      if (table_pkts[slot] != 32'hFFFF_FFFF) table_pkts[slot]++;
      if (49'h0_FFFF_FFFF_FFFF - table_bytes[slot] < pay)
         table_bytes[slot] = 48'hFFFF_FFFF_FFFF;
      else
         table_bytes[slot] = table_bytes[slot] + pay;
      r = entry_report(slot);
      r.status = ST_COUNTED;
      r.payload = pay[15:0];
      return r;
   endfunction

   // Advance the predictor by one accepted request.
   task automatic predict_request(request_type q);
      report_type r;
      int idx, hdr_end, len;
      if (q.act == ACT_READ) begin
         r = '0;
         if (table_used[q.index]) r = entry_report(q.index);
         r.kind = KIND_READ;
         r.status = ST_COUNTED;
         r.entry_index = q.index;
         expected_reports.push_back(r);
         return;
      end
      idx = frame_pos;
      hdr_end = 14 + ver_ihl[3:0] * 4;
      case (idx)
         12: ether_kind = {q.data, 8'h00};
         13: ether_kind[7:0] = q.data;
         14: ver_ihl = q.data;
         23: proto = q.data;
         default: ;
      endcase
      if (idx >= 26 && idx <= 29) hdr_saddr = {hdr_saddr[23:0], q.data};
      else if (idx >= 30 && idx <= 33) hdr_daddr = {hdr_daddr[23:0], q.data};
      if (idx == hdr_end) hdr_sport[15:8] = q.data;
      else if (idx == hdr_end + 1) hdr_sport[7:0] = q.data;
      else if (idx == hdr_end + 2) hdr_dport[15:8] = q.data;
      else if (idx == hdr_end + 3) hdr_dport[7:0] = q.data;
      else if (idx == hdr_end + 12) tcp_words = q.data[7:4];
      len = (idx < 65535) ? idx + 1 : 65535;
      if (!q.last) begin
         frame_pos = len;
         return;
      end
      frame_pos = 0;
      expected_reports.push_back(close_frame(len));
   endtask

   // Driver: offer the head of the queue, hold it until taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request(pending_requests.pop_front());
         end
         if ((!req_tvalid || req_tready) ) begin
            if ((req_tvalid && req_tready ? pending_requests.size() : pending_requests.size())
                != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_requests[0].act;
               req_tdata  <= {2'b00, pending_requests[0].index, pending_requests[0].data};
               req_tlast  <= pending_requests[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response against the oldest expected report.
   always @(posedge clock) begin
      report_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[1:0], rsp_tdata[7:2], rsp_tdata[8],
                   rsp_tdata[40:9], rsp_tdata[72:41], rsp_tdata[88:73],
                   rsp_tdata[104:89], rsp_tdata[120:105], rsp_tdata[152:121],
                   rsp_tdata[200:153]};
            if (expected_reports.size() == 0) begin
               $error("unexpected response kind %0d", got.kind);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               if (got.kind != want.kind) begin
                  $error("kind exp %0h got %0h", want.kind, got.kind); failures++;
               end
               if (got.status != want.status) begin
                  $error("status exp %0h got %0h", want.status, got.status); failures++;
               end
               if (got.entry_index != want.entry_index) begin
                  $error("entry_index exp %0h got %0h", want.entry_index,
                         got.entry_index);
                  failures++;
               end
               if (got.entry_valid != want.entry_valid) begin
                  $error("entry_valid exp %0h got %0h", want.entry_valid,
                         got.entry_valid);
                  failures++;
               end
               if (got.saddr != want.saddr) begin
                  $error("source_address exp %0h got %0h", want.saddr, got.saddr);
                  failures++;
               end
               if (got.daddr != want.daddr) begin
                  $error("destination_address exp %0h got %0h", want.daddr, got.daddr);
                  failures++;
               end
               if (got.sport != want.sport) begin
                  $error("src_port exp %0h got %0h", want.sport, got.sport);
                  failures++;
               end
               if (got.dport != want.dport) begin
                  $error("destination_port exp %0h got %0h", want.dport, got.dport);
                  failures++;
               end
               if (got.payload != want.payload) begin
                  $error("payload_bytes exp %0h got %0h", want.payload, got.payload);
                  failures++;
               end
               if (got.pkts != want.pkts) begin
                  $error("packet_total exp %0h got %0h", want.pkts, got.pkts);
                  failures++;
               end
               if (got.bytes != want.bytes) begin
                  $error("byte_total exp %0h got %0h", want.bytes, got.bytes);
                  failures++;
               end
            end
         end
         // Long hold-off counts down here; otherwise stall at random.
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Queue one frame byte by byte; the last byte carries the mark.
   task automatic add_frame(logic [7:0] frame[$]);
      request_type q;
      foreach (frame[i]) begin
         q = '0;
         q.act = ACT_BYTE;
         q.data = frame[i];
         q.last = (i == frame.size() - 1);
         pending_requests.push_back(q);
      end
   endtask

   task automatic add_read(logic [5:0] index);
      request_type q;
      q = '0;
      q.act = ACT_READ;
      q.index = index;
      q.data = $urandom;
      q.last = $urandom;
      pending_requests.push_back(q);
   endtask

   // Build an IPv4 frame; ihl and tcp offset are raw header fields.
   task automatic add_ip_frame(logic [7:0] prot, logic [3:0] ihl, logic [3:0] toff,
                               logic [31:0] sa, logic [31:0] da,
                               logic [15:0] sp, logic [15:0] dp, int pay_len);
      logic [7:0] f[$];
      int l4;
      for (int i = 0; i < 12; i++) f.push_back($urandom);
      f.push_back(8'h08); f.push_back(8'h00);
      f.push_back({IP_VER4, ihl});
      for (int i = 15; i < 23; i++) f.push_back($urandom);
      f.push_back(prot);
      f.push_back($urandom); f.push_back($urandom);
      for (int i = 3; i >= 0; i--) f.push_back(sa[i*8 +: 8]);
      for (int i = 3; i >= 0; i--) f.push_back(da[i*8 +: 8]);
      for (int i = 20; i < ihl * 4; i++) f.push_back($urandom);
      f.push_back(sp[15:8]); f.push_back(sp[7:0]);
      f.push_back(dp[15:8]); f.push_back(dp[7:0]);
      l4 = (prot == PROTO_TCP) ? 20 : 8;
      for (int i = 4; i < l4; i++)
         f.push_back((i == 12 && prot == PROTO_TCP) ? {toff, 4'($urandom)} : 8'($urandom));
      for (int i = 0; i < pay_len; i++) f.push_back($urandom);
      add_frame(f);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [7:0]  junk[$];
      logic [31:0] sa_pool[4];
      int          n;
      for (int i = 0; i < FLOW_ENTRIES; i++) table_used[i] = 1'b0;
      flows_used = 0;
      frame_pos = 0; ether_kind = 0; ver_ihl = 0; proto = 0;
      hdr_saddr = 0; hdr_daddr = 0; hdr_sport = 0; hdr_dport = 0; tcp_words = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: read of empty entry, extremes, both protocols, odd headers.
      add_read(6'd0);
      add_read(6'd63);
      add_ip_frame(PROTO_UDP, 4'd5, 4'd0, 32'h0, 32'h0, 16'h0, 16'h0, 0);
      add_ip_frame(PROTO_TCP, 4'd15, 4'd5, '1, '1, '1, '1, 3);
      add_ip_frame(PROTO_TCP, 4'd5, 4'd15, 32'hA5A5_5A5A, 32'h1, 16'h8000, 16'h1, 2);
      add_ip_frame(8'd1, 4'd5, 4'd5, 32'h1, 32'h2, 16'h3, 16'h4, 1);
      add_ip_frame(PROTO_UDP, 4'd4, 4'd0, 32'h1, 32'h2, 16'h3, 16'h4, 1);
      junk = {}; repeat (3) junk.push_back($urandom); add_frame(junk);
      junk = {}; junk.push_back(8'hFF); add_frame(junk);
      add_ip_frame(PROTO_UDP, 4'd5, 4'd0, 32'h0, 32'h0, 16'h0, 16'h0, 40);
      add_read(6'd0);
      add_read(6'd1);
      // Read in the middle of a frame: the frame continues afterwards.
      add_ip_frame(PROTO_UDP, 4'd5, 4'd0, 32'hC0A8_0001, 32'hC0A8_0002, 16'd53, 16'd53, 4);
      pending_requests.insert(pending_requests.size() - 10, '{ACT_READ, 8'hFF, 1'b1, 6'd2});

      // Random: mostly well-formed frames over a small key pool, plus noise.
      for (int i = 0; i < 4; i++) sa_pool[i] = $urandom;
      for (int phase = 0; phase < 3; phase++) begin
         n = 0;
         if (phase == 1) begin send_idle_pct = 71; recv_idle_pct = 29; end
         if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         while (n < 2) begin
            case ($urandom_range(9))
               0: add_read($urandom);
               1: begin
                  junk = {};
                  repeat ($urandom_range(1, 40)) junk.push_back($urandom);
                  add_frame(junk);
               end
               2: add_ip_frame($urandom_range(1) ? PROTO_TCP : PROTO_UDP, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom_range(0, 6));
               default: add_ip_frame($urandom_range(1) ? PROTO_TCP : PROTO_UDP,
                                     $urandom_range(5, 6), $urandom_range(4, 7),
                                     sa_pool[$urandom_range(3)], $urandom_range(3),
                                     $urandom_range(1), $urandom_range(2) << 14,
                                     $urandom_range(0, 8));
            endcase
            n++;
         end
         if (phase == 0) begin
            hold_off_cycles = 400;
         end
         wait_drained();
      end
      // Read back a spread of entries, used and unused.
      for (int i = 0; i < 6; i++) add_read($urandom);
      add_read(6'd63);
      wait_drained();
      repeat (100) @(posedge clock);
      testing_done = 1'b1;
      if (failures == 0 && expected_reports.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #20ms;
      if (!testing_done) $display("Mismatches found");
      $finish;
   end

endmodule
